[rtl/core/rrfo_pkg.sv]
// Shared types and constants for the rectangle rasterizer.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package rrfo_pkg;

  localparam int COORD_W   = 20;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [CFG_W-1:0]  CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0]  CANVAS_HEIGHT_RST = 9'd256;
  localparam logic [BYTE_W-1:0] BACKGROUND_RST    = 8'd32;

  localparam logic [BYTE_W-1:0] KIND_FILLED  = 8'h52;
  localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'h72;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
  } rect_t;

  // Request from the controller to the sweep unit
  typedef struct packed {
    logic              start;
    logic              cover_all;
    logic              outline;
    logic [BYTE_W-1:0] color;
    rect_t             rect;
  } sweep_req_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] pixel;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_READ,
    S_RESULT
  } ctrl_state_e;

endpackage

`default_nettype wire

[rtl/core/rrfo_in_if.sv]
// Command channel: valid/ready handshake plus the command payload.
// Depends on rrfo_pkg for field widths.
`default_nettype none

interface rrfo_in_if
  import rrfo_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic signed [COORD_W-1:0] rect_width;
  logic signed [COORD_W-1:0] rect_height;
  logic [BYTE_W-1:0]         rect_kind;
  logic [BYTE_W-1:0]         draw_color;
  logic [BYTE_W-1:0]         read_col;
  logic [BYTE_W-1:0]         read_row;

  modport source (
    output valid, command, rect_x, rect_y, rect_width, rect_height,
           rect_kind, draw_color, read_col, read_row,
    input  ready
  );

  modport sink (
    input  valid, command, rect_x, rect_y, rect_width, rect_height,
           rect_kind, draw_color, read_col, read_row,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/rrfo_out_if.sv]
// Result channel: valid/ready handshake plus status and pixel byte.
// Depends on rrfo_pkg for field widths.
`default_nettype none

interface rrfo_out_if
  import rrfo_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] pixel_value;

  modport source (
    output valid, status, pixel_value,
    input  ready
  );

  modport sink (
    input  valid, status, pixel_value,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/rect_raster_fill_outline_top.sv]
// Rectangle rasterizer top level: command sequencer, configuration registers,
// result register, canvas memory and sweep unit. Depends on rrfo_pkg,
// rrfo_in_if, rrfo_out_if, rrfo_canvas_ram and rrfo_sweep.
//
// Usage: configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle. Commands arrive on in_i, one transaction at a time; each
// gives exactly one result transaction on out_o (status, pixel_value).
// A clear or an accepted draw sweeps the whole canvas in use, one cell per
// cycle through the single memory write port. A rejected draw, an unused
// command or a read outside the canvas answers without a memory access; a
// cell read answers after one memory read.
// in_i.ready is high whenever the sequencer is idle, so the next command is
// taken while the previous result still waits in the output register; if
// the receiver stalls, the sequencer holds its finished result until the
// output register frees. Reset restores the size and background registers
// and clears all control state; canvas contents are undefined until cleared
// or drawn.
`default_nettype none

module rect_raster_fill_outline_top
  import rrfo_pkg::*;
#(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  rrfo_in_if.sink                   in_i,
  rrfo_out_if.source                out_o
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int LW    = (SW > CFG_W) ? SW : CFG_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]  cfg_w_q, cfg_h_q;
  logic [BYTE_W-1:0] bg_q;
  logic [SW-1:0]     side_w, side_h;

  ctrl_state_e state_q, state_d;

  logic [CMD_W-1:0]  cmd_q;
  rect_t             rect_q;
  logic [BYTE_W-1:0] kind_q, color_q, rcol_q, rrow_q;

  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  sweep_req_t        sweep_req;
  logic              sweep_done;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic accept, reject, read_ok;

  // Sizes above the canvas capacity act as the capacity
  assign side_w = (LW'(cfg_w_q) > LW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_w_q);
  assign side_h = (LW'(cfg_h_q) > LW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg_h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CANVAS_WIDTH_RST;
      cfg_h_q <= CANVAS_HEIGHT_RST;
      bg_q    <= BACKGROUND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_CANVAS_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_BACKGROUND:    bg_q    <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Hold the command fields for the rest of the operation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_i.command;
      rect_q  <= '{x: in_i.rect_x, y: in_i.rect_y,
                   w: in_i.rect_width, h: in_i.rect_height};
      kind_q  <= in_i.rect_kind;
      color_q <= in_i.draw_color;
      rcol_q  <= in_i.read_col;
      rrow_q  <= in_i.read_row;
    end
  end

  assign reject = (rect_q.w <= 0) || (rect_q.h <= 0) ||
                  ((kind_q != KIND_FILLED) && (kind_q != KIND_OUTLINE));
  assign read_ok = (LW'(rcol_q) < LW'(side_w)) && (LW'(rrow_q) < LW'(side_h));

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_re      = 1'b0;
    ram_raddr   = AW'(32'(rrow_q) * MAX_SIDE + 32'(rcol_q));
    sweep_req   = '{start: 1'b0, cover_all: 1'b0, outline: 1'b0,
                    color: color_q, rect: rect_q};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d = '0;
        case (cmd_q)
          CMD_CLEAR: begin
            sweep_req.start     = 1'b1;
            sweep_req.cover_all = 1'b1;
            sweep_req.color     = bg_q;
            state_d             = S_SWEEP;
          end
          CMD_DRAW: begin
            if (reject) begin
              res_d.status = 1'b1;
              state_d      = S_RESULT;
            end else begin
              sweep_req.start   = 1'b1;
              sweep_req.outline = (kind_q == KIND_OUTLINE);
              state_d           = S_SWEEP;
            end
          end
          CMD_READ: begin
            if (read_ok) begin
              ram_re  = 1'b1;
              state_d = S_READ;
            end else begin
              state_d = S_RESULT;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_SWEEP: begin
        if (sweep_done) begin
          state_d = S_RESULT;
        end
      end
      S_READ: begin
        res_d.pixel = ram_rdata;
        state_d     = S_RESULT;
      end
      S_RESULT: begin
        // Move into the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.pixel_value = out_q.pixel;

  rrfo_sweep #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .AW        (AW)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sweep_req),
    .side_w_i (side_w),
    .side_h_i (side_h),
    .we_o     (ram_we),
    .waddr_o  (ram_waddr),
    .wdata_o  (ram_wdata),
    .done_o   (sweep_done)
  );

  rrfo_canvas_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/rrfo_canvas_ram.sv]
// Canvas byte memory: one write port, one read port, registered read data.
// Depends on rrfo_pkg for the byte width.
`default_nettype none

module rrfo_canvas_ram
  import rrfo_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rrfo_sweep.sv]
// Canvas sweep: walks every cell in use, one per cycle, and writes the
// covered ones. Used for clear and for rectangle draws. Depends on rrfo_pkg.
`default_nettype none

module rrfo_sweep
  import rrfo_pkg::*;
#(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8,
  parameter int SW        = 9,
  parameter int AW        = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sweep_req_t        req_i,
  input  wire logic [SW-1:0]     side_w_i,
  input  wire logic [SW-1:0]     side_h_i,
  output logic                   we_o,
  output logic      [AW-1:0]     waddr_o,
  output logic      [BYTE_W-1:0] wdata_o,
  output logic                   done_o
);

  localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int XW0  = CW + FRAC_BITS + 2;
  localparam int XW   = (XW0 > 23) ? XW0 : 23;
  localparam logic signed [XW-1:0] ONE = XW'(1) << FRAC_BITS;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          all_q, all_d;
  logic          outline_q, outline_d;
  logic [BYTE_W-1:0] color_q, color_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [AW-1:0] base_q, base_d;

  // Edge thresholds: lo/hi bound the rectangle, in/out mark the outline band
  logic signed [XW-1:0] x_lo_q, x_hi_q, x_in_q, x_out_q;
  logic signed [XW-1:0] y_lo_q, y_hi_q, y_in_q, y_out_q;
  logic signed [XW-1:0] rx, ry, rw, rh, rxe, rye;
  logic signed [XW-1:0] px, py;

  logic col_in, row_in, near_x, near_y, covered;
  logic last_col, last_row, empty;

  assign rx  = XW'(req_i.rect.x);
  assign ry  = XW'(req_i.rect.y);
  assign rw  = XW'(req_i.rect.w);
  assign rh  = XW'(req_i.rect.h);
  assign rxe = rx + rw;
  assign rye = ry + rh;

  assign px = XW'(col_q) << FRAC_BITS;
  assign py = XW'(row_q) << FRAC_BITS;

  assign col_in  = (px >= x_lo_q) && (px <= x_hi_q);
  assign row_in  = (py >= y_lo_q) && (py <= y_hi_q);
  assign near_x  = (px < x_in_q) || (px > x_out_q);
  assign near_y  = (py < y_in_q) || (py > y_out_q);
  assign covered = all_q || (col_in && row_in && (!outline_q || near_x || near_y));

  assign last_col = (SW'(col_q) == side_w_i - SW'(1));
  assign last_row = (SW'(row_q) == side_h_i - SW'(1));
  assign empty    = (side_w_i == '0) || (side_h_i == '0);

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    all_d     = all_q;
    outline_d = outline_q;
    color_d   = color_q;
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    if (req_i.start) begin
      all_d     = req_i.cover_all;
      outline_d = req_i.outline;
      color_d   = req_i.color;
      col_d     = '0;
      row_d     = '0;
      base_d    = '0;
      if (empty) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!last_col) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d  = '0;
        row_d  = row_q + CW'(1);
        base_d = base_q + AW'(MAX_SIDE);
        if (last_row) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    all_q     <= all_d;
    outline_q <= outline_d;
    color_q   <= color_d;
    col_q     <= col_d;
    row_q     <= row_d;
    base_q    <= base_d;
    if (req_i.start) begin
      x_lo_q  <= rx;
      x_hi_q  <= rxe;
      x_in_q  <= rx + ONE;
      x_out_q <= rxe - ONE;
      y_lo_q  <= ry;
      y_hi_q  <= rye;
      y_in_q  <= ry + ONE;
      y_out_q <= rye - ONE;
    end
  end

  assign we_o    = busy_q && covered;
  assign waddr_o = base_q + AW'(col_q);
  assign wdata_o = color_q;
  assign done_o  = done_q;

endmodule

`default_nettype wire
